// ----- sv/imu_fd_pkg.sv -----
// Shared types, constants and helpers for the IMU frame deframer.
`timescale 1ns / 1ps
package imu_fd_pkg;

  localparam int FRAME_BYTES = 11;
  // bytes held between items; the last frame byte is the incoming item
  localparam int WIN_DEPTH   = FRAME_BYTES - 1;
  localparam int WIN_IDX_W   = $clog2(WIN_DEPTH + 1);

  localparam logic [7:0] SYNC_RST     = 8'h55;
  localparam logic [7:0] MASK_RST     = 8'h50;
  localparam logic [7:0] REC_END_TYPE = 8'h5A;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_SYNC = 1'b0,
    REG_MASK = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] sync_value;
    logic [7:0] type_mask;
  } cfg_regs_t;

  typedef struct packed {
    logic               valid;
    logic [7:0]         frame_type;
    logic               known_type;
    logic               record_end;
    logic signed [15:0] word_zero;
    logic signed [15:0] word_one;
    logic signed [15:0] word_two;
    logic signed [15:0] word_three;
  } frame_res_t;

  // types the sensor defines: 0x50..0x54 and 0x56..0x5A
  function automatic logic is_known_type(input logic [7:0] t);
    return (t inside {[8'h50:8'h54], [8'h56:8'h5A]});
  endfunction

endpackage

// ----- sv/imu_fd_cfg.sv -----
// APB-style configuration registers: sync byte and type mask.
`timescale 1ns / 1ps
module imu_fd_cfg (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output imu_fd_pkg::cfg_regs_t regs
);
  import imu_fd_pkg::*;

  logic [7:0] sync_r, sync_nxt;
  logic [7:0] mask_r, mask_nxt;
  logic       wr_en;
  reg_idx_t   idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = reg_idx_t'(paddr[2]);

  // register write decode
  always_comb begin
    sync_nxt = sync_r;
    mask_nxt = mask_r;
    if (wr_en) begin
      case (idx)
        REG_SYNC: sync_nxt = pwdata[7:0];
        REG_MASK: mask_nxt = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r <= SYNC_RST;
      mask_r <= MASK_RST;
    end else begin
      sync_r <= sync_nxt;
      mask_r <= mask_nxt;
    end
  end

  // read mux
  always_comb begin
    case (idx)
      REG_SYNC: prdata = {24'd0, sync_r};
      REG_MASK: prdata = {24'd0, mask_r};
      default:  prdata = 32'd0;
    endcase
  end

  assign regs.sync_value = sync_r;
  assign regs.type_mask  = mask_r;

endmodule

// ----- sv/imu_fd_window.sv -----
// Byte window, frame checks and result decode for the deframer.
`timescale 1ns / 1ps
module imu_fd_window (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step,
  input  logic [7:0]             rx_byte,
  input  imu_fd_pkg::cfg_regs_t  regs,
  output imu_fd_pkg::frame_res_t res
);
  import imu_fd_pkg::*;

  logic [7:0]           win_r   [WIN_DEPTH];
  logic [7:0]           win_nxt [WIN_DEPTH];
  logic [WIN_IDX_W-1:0] cnt_r, cnt_nxt;
  logic                 full;
  logic [7:0]           sum;
  logic                 pass;

  assign full = (cnt_r == WIN_IDX_W'(WIN_DEPTH));

  // checksum over the ten held bytes
  always_comb begin
    sum = 8'd0;
    for (int i = 0; i < WIN_DEPTH; i++) begin
      sum = sum + win_r[i];
    end
  end

  assign pass = (win_r[0] == regs.sync_value) &&
                ((win_r[1] & regs.type_mask) == regs.type_mask) &&
                (sum == rx_byte);

  // window update: fill, clear on a good frame, slide by one on a bad one
  always_comb begin
    for (int i = 0; i < WIN_DEPTH; i++) begin
      win_nxt[i] = win_r[i];
    end
    cnt_nxt = cnt_r;
    if (step) begin
      if (!full) begin
        win_nxt[cnt_r] = rx_byte;
        cnt_nxt        = cnt_r + 1'b1;
      end else if (pass) begin
        cnt_nxt = '0;
      end else begin
        for (int i = 0; i < WIN_DEPTH - 1; i++) begin
          win_nxt[i] = win_r[i+1];
        end
        win_nxt[WIN_DEPTH-1] = rx_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < WIN_DEPTH; i++) begin
      win_r[i] <= win_nxt[i];
    end
  end

  // result decode
  always_comb begin
    res.valid      = step && full && pass;
    res.frame_type = win_r[1];
    res.known_type = is_known_type(win_r[1]);
    res.record_end = (win_r[1] == REC_END_TYPE);
    res.word_zero  = {win_r[3], win_r[2]};
    res.word_one   = {win_r[5], win_r[4]};
    res.word_two   = {win_r[7], win_r[6]};
    res.word_three = {win_r[9], win_r[8]};
  end

  // fill count never passes the held depth
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= WIN_IDX_W'(WIN_DEPTH))
    else $error("window fill count out of range");

  // a good frame empties the window
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |=> cnt_r == '0)
    else $error("window not cleared after frame");

  // a bad full frame keeps the window full
  a_slide: assert property (@(posedge clk) disable iff (!rst_n)
    step && full && !pass |=> full)
    else $error("window lost bytes on rejected frame");

endmodule

// ----- sv/imu_frame_deframer_top.sv -----
// Top level of the IMU serial frame deframer.
// Usage:
//   in_*  : stream of received serial bytes, one byte per item in in_tdata.
//   out_* : one item per frame that passes the sync, type-mask and checksum
//           checks; four signed little-endian payload words in out_tdata,
//           type byte and known-type flag in out_tuser, out_tlast set for
//           the final record type (0x5A) of a set.
//   cfg_* : APB-style registers, sync byte at 0x0 and type mask at 0x4.
// Timing: a byte is captured in the input register at its accept edge and
//   checked against the ten held bytes while it sits there; its result is
//   loaded into the result register when the byte moves on, which an
//   output stall can hold off.
//   One byte per cycle is taken sustained while out_tready is high; the
//   window update, 10-byte checksum tree and result register run together.
// Reset: window empty, no result pending, sync 0x55 and mask 0x50.
// Stall: while out_tvalid is high and out_tready low, the input register
//   holds its byte and in_tready drops once that register is occupied.
`timescale 1ns / 1ps
module imu_frame_deframer_top (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [15:0] word_zero, [31:16] word_one,
                                  // [47:32] word_two, [63:48] word_three
  output logic [8:0]  out_tuser,  // [7:0] frame_type, [8] known_type
  output logic        out_tlast,  // record_end
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import imu_fd_pkg::*;

  cfg_regs_t  regs;
  frame_res_t res;

  logic        in_vld_r, in_vld_nxt;
  logic [7:0]  in_byte_r;
  logic        adv;
  logic        out_vld_r, out_vld_nxt;
  logic [63:0] out_data_r;
  logic [8:0]  out_user_r;
  logic        out_last_r;

  imu_fd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .regs    (regs)
  );

  imu_fd_window u_win (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (adv),
    .rx_byte (in_byte_r),
    .regs    (regs),
    .res     (res)
  );

  // the held byte moves on when the result register is free or draining
  assign adv       = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || adv;

  // input register
  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_tvalid && in_tready) begin
      in_vld_nxt = 1'b1;
    end else if (adv) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
    end
  end

  // result register
  always_comb begin
    out_vld_nxt = out_vld_r;
    if (adv) begin
      out_vld_nxt = res.valid;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res.valid) begin
      out_data_r <= {res.word_three, res.word_two, res.word_one, res.word_zero};
      out_user_r <= {res.known_type, res.frame_type};
      out_last_r <= res.record_end;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

  // a pending result is never overwritten while stalled
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    !(res.valid && out_vld_r && !out_tready))
    else $error("result produced while output stalled");

  // final record type is always a known type
  a_last_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser[8])
    else $error("record end on unknown type");

  // a stalled result keeps the input byte parked
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && out_vld_r && !out_tready |=> in_vld_r && $stable(in_byte_r))
    else $error("input byte lost during output stall");

endmodule

// ----- tb/sv/imu_frame_deframer_top_tb.sv -----
// Self-checking testbench for the IMU frame deframer top level.
`timescale 1ns / 1ps
module imu_frame_deframer_top_tb;
  import imu_fd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  // fields of one decoded frame, as the block reports them
  typedef struct packed {
    logic [7:0]         frame_type;
    logic               known_type;
    logic               record_end;
    logic signed [15:0] word_zero;
    logic signed [15:0] word_one;
    logic signed [15:0] word_two;
    logic signed [15:0] word_three;
  } frame_fields_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;   // [7:0] rx_byte
  logic        out_tvalid;
  logic        out_tready = 1'b1;
  logic [63:0] out_tdata;          // [15:0] word_zero, [31:16] word_one,
                                   // [47:32] word_two, [63:48] word_three
  logic [8:0]  out_tuser;          // [7:0] frame_type, [8] known_type
  logic        out_tlast;          // record_end
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = 3'd0;
  logic [31:0] cfg_pwdata = 32'd0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // deframer shadow state
  logic [7:0]    win_bytes [FRAME_BYTES];
  int            win_fill;
  logic [7:0]    sync_cfg;
  logic [7:0]    mask_cfg;
  frame_fields_t pending_frames [$];

  int  bytes_sent;
  int  fail_count;
  int  shown_count;
  int  cycle_count;
  int  stall_left;
  bit  src_idle;
  bit  sink_idle;

  imu_frame_deframer_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #10 clk = ~clk;

  // run-away guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("imu_frame_deframer_top_tb: done, errors");
      $finish;
    end
  end

  // mostly no gap, some short, a few long
  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // result sink back-pressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else begin
      out_tready <= 1'b1;
      if (sink_idle && $urandom_range(0, 99) < 25) stall_left = rand_gap();
    end
  end

  // shift one byte into the shadow window; queue a frame when all checks pass
  function automatic void deframe_byte(input logic [7:0] b);
    int            i;
    logic [7:0]    sum;
    logic [7:0]    t;
    frame_fields_t r;
    if (win_fill >= FRAME_BYTES) win_fill = FRAME_BYTES - 1;
    win_bytes[win_fill] = b;
    win_fill++;
    if (win_fill < FRAME_BYTES) return;
    sum = 8'h00;
    for (i = 0; i < FRAME_BYTES - 1; i++) sum = sum + win_bytes[i];
    t = win_bytes[1];
    if (win_bytes[0] != sync_cfg || (t & mask_cfg) != mask_cfg ||
        sum != win_bytes[FRAME_BYTES - 1]) begin
      // reject: drop the oldest byte
      for (i = 0; i < FRAME_BYTES - 1; i++) win_bytes[i] = win_bytes[i + 1];
      win_bytes[FRAME_BYTES - 1] = 8'h00;
      win_fill = FRAME_BYTES - 1;
      return;
    end
    r.frame_type = t;
    r.known_type = (t >= 8'h50 && t <= 8'h54) || (t >= 8'h56 && t <= 8'h5A);
    r.record_end = (t == REC_END_TYPE);
    r.word_zero  = {win_bytes[3], win_bytes[2]};
    r.word_one   = {win_bytes[5], win_bytes[4]};
    r.word_two   = {win_bytes[7], win_bytes[6]};
    r.word_three = {win_bytes[9], win_bytes[8]};
    pending_frames.push_back(r);
    for (i = 0; i < FRAME_BYTES; i++) win_bytes[i] = 8'h00;
    win_fill = 0;
  endfunction

  // compare each delivered frame with the oldest one predicted
  always @(posedge clk) begin : check_frames
    frame_fields_t got;
    frame_fields_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.frame_type = out_tuser[7:0];
      got.known_type = out_tuser[8];
      got.record_end = out_tlast;
      got.word_zero  = out_tdata[15:0];
      got.word_one   = out_tdata[31:16];
      got.word_two   = out_tdata[47:32];
      got.word_three = out_tdata[63:48];
      if (pending_frames.size() == 0) begin
        fail_count++;
        if (shown_count < 10) begin
          shown_count++;
          $display("unexpected frame: got %h", got);
        end
      end else begin
        want = pending_frames.pop_front();
        if (got !== want) begin
          fail_count++;
          if (shown_count < 10) begin
            shown_count++;
            $display("frame mismatch: exp type=%h known=%b end=%b w=%h %h %h %h",
                     want.frame_type, want.known_type, want.record_end,
                     want.word_zero, want.word_one, want.word_two, want.word_three);
            $display("                got type=%h known=%b end=%b w=%h %h %h %h",
                     got.frame_type, got.known_type, got.record_end,
                     got.word_zero, got.word_one, got.word_two, got.word_three);
          end
        end
      end
    end
  end

  // send one item; valid stays high when the next item follows at once
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = src_idle ? rand_gap() : 0;
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
    deframe_byte(b);
  endtask

  // build a frame with its checksum, optionally corrupted or cut short
  task automatic send_frame(input logic [7:0] sy, input logic [7:0] ty,
                            input logic [63:0] payload, input logic [7:0] csum_flip,
                            input int keep);
    logic [87:0] f;
    logic [7:0]  csum;
    int          i;
    f[79:0] = {payload, ty, sy};
    csum = 8'h00;
    for (i = 0; i < FRAME_BYTES - 1; i++) csum = csum + f[8*i +: 8];
    f[87:80] = csum ^ csum_flip;
    for (i = 0; i < keep; i++) send_byte(f[8*i +: 8]);
  endtask

  task automatic wait_frames_drained();
    while (pending_frames.size() != 0) @(posedge clk);
  endtask

  // stop sending, let every frame out, then allow for the pipeline
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    wait_frames_drained();
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_write(input reg_idx_t idx, input logic [31:0] val);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      REG_SYNC: sync_cfg = val[7:0];
      REG_MASK: mask_cfg = val[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // only the low byte counts; the upper bits carry noise
  task automatic set_config(input logic [7:0] sy, input logic [7:0] mk);
    settle();
    apb_write(REG_SYNC, {24'($urandom), sy});
    apb_write(REG_MASK, {24'($urandom), mk});
  endtask

  task automatic test_directed_frames();
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    send_frame(8'h55, 8'h50, 64'h0, 8'h00, 11);
    send_frame(8'h55, 8'h5A, {64{1'b1}}, 8'h00, 11);
    send_frame(8'h55, 8'h54, 64'hFFFE_0001_7FFF_8000, 8'h00, 11);
    send_frame(8'h55, 8'h56, 64'h1234_5678_9ABC_DEF0, 8'h00, 11);
    send_frame(8'h55, 8'h59, 64'h8001_7FFE_00FF_FF00, 8'h00, 11);
    // type with the mask bits but not a defined record: still accepted
    send_frame(8'h55, 8'h55, 64'h0102_0304_0506_0708, 8'h00, 11);
    send_frame(8'h55, 8'h5B, 64'hA5A5_5A5A_A5A5_5A5A, 8'h00, 11);
    send_frame(8'h55, 8'hFF, 64'h0F0F_F0F0_0F0F_F0F0, 8'h00, 11);
    // bad checksum, then a clean frame that has to resync
    send_frame(8'h55, 8'h51, 64'h1111_2222_3333_4444, 8'h01, 11);
    send_frame(8'h55, 8'h52, 64'h5555_6666_7777_8888, 8'h00, 11);
    // wrong sync and a type missing mask bits
    send_frame(8'h54, 8'h53, 64'hCAFE_BABE_DEAD_BEEF, 8'h00, 11);
    send_frame(8'h55, 8'h4F, 64'h0, 8'h00, 11);
    // stray sync byte ahead of a frame
    send_byte(8'h55);
    send_frame(8'h55, 8'h57, 64'h7FFF_8000_7FFF_8000, 8'h00, 11);
    send_frame(8'h55, 8'h58, 64'h0, 8'h00, 11);
  endtask

  task automatic test_register_extremes();
    set_config(8'h00, 8'h00);
    send_frame(8'h00, 8'h00, 64'h0, 8'h00, 11);
    send_frame(8'h00, 8'h5A, 64'h8000_8000_8000_8000, 8'h00, 11);
    set_config(8'hFF, 8'hFF);
    send_frame(8'hFF, 8'hFF, {64{1'b1}}, 8'h00, 11);
    send_frame(8'hFF, 8'h5A, 64'h0, 8'h00, 11);
    send_frame(8'hFF, 8'hFF, 64'h0123_4567_89AB_CDEF, 8'h00, 11);
  endtask

  // mostly well-formed frames, with corrupt, truncated and noise runs
  task automatic test_random_traffic(input int n_bytes, input bit pause_midway);
    int          start;
    int          kind;
    int          i;
    bit          paused;
    logic [7:0]  ty;
    logic [7:0]  bad;
    logic [63:0] pl;
    start  = bytes_sent;
    paused = 1'b0;
    while (bytes_sent - start < n_bytes) begin
      if (pause_midway && !paused && bytes_sent - start >= n_bytes / 2) begin
        paused = 1'b1;
        settle();
      end
      if ($urandom_range(0, 1) != 0) ty = 8'h50 + 8'($urandom_range(0, 10));
      else ty = 8'($urandom_range(0, 255));
      ty   = ty | mask_cfg;
      pl   = {$urandom, $urandom};
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        send_frame(sync_cfg, ty, pl, 8'h00, 11);
      end else if (kind < 70) begin
        send_frame(sync_cfg, ty, pl, 8'($urandom_range(1, 255)), 11);
      end else if (kind < 77) begin
        send_frame(sync_cfg ^ 8'($urandom_range(1, 255)), ty, pl, 8'h00, 11);
      end else if (kind < 84 && mask_cfg != 8'h00) begin
        bad = mask_cfg & 8'($urandom_range(1, 255));
        if (bad == 8'h00) bad = mask_cfg;
        send_frame(sync_cfg, ty ^ bad, pl, 8'h00, 11);
      end else if (kind < 92) begin
        for (i = 0; i < $urandom_range(1, 5); i++) send_byte(8'($urandom));
      end else begin
        send_frame(sync_cfg, ty, pl, 8'h00, $urandom_range(1, 10));
      end
    end
  endtask

  initial begin
    for (int i = 0; i < FRAME_BYTES; i++) win_bytes[i] = 8'h00;
    win_fill    = 0;
    sync_cfg    = SYNC_RST;
    mask_cfg    = MASK_RST;
    bytes_sent  = 0;
    fail_count  = 0;
    shown_count = 0;
    cycle_count = 0;
    stall_left  = 0;
    src_idle    = 1'b0;
    sink_idle   = 1'b0;

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    test_directed_frames();
    test_register_extremes();

    set_config(8'h55, 8'h50);
    src_idle = 1'b1; sink_idle = 1'b1;
    test_random_traffic(320, 1'b1);

    set_config(8'h00, 8'h00);
    src_idle = 1'b0; sink_idle = 1'b0;
    test_random_traffic(320, 1'b0);

    set_config(8'hFF, 8'hFF);
    src_idle = 1'b1; sink_idle = 1'b0;
    test_random_traffic(320, 1'b0);

    set_config(8'($urandom), 8'($urandom) & 8'($urandom));
    src_idle = 1'b0; sink_idle = 1'b1;
    test_random_traffic(320, 1'b0);

    set_config(8'($urandom), 8'h50 | 8'($urandom_range(0, 3)));
    src_idle = 1'b1; sink_idle = 1'b1;
    test_random_traffic(320, 1'b1);

    settle();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending_frames.size() == 0) begin
      $display("imu_frame_deframer_top_tb: done, clean");
    end else begin
      $display("imu_frame_deframer_top_tb: done, errors");
    end
    $finish;
  end

endmodule
